### hdl/bc1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC1 decoder package
// Shared types, register indexes and the constant arithmetic helpers used to
// expand RGB565 endpoints and to build the interpolated palette entries.
// ----------------------------------------------------------------------------
package bc1_pkg;

   localparam int DimWidth   = 15;   // width of the size registers
   localparam int CountWidth = 12;   // block column and line counters
   localparam int PosWidth   = 14;   // output pixel positions

   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   localparam logic [7:0] OpaqueAlpha = 8'hFF;

   // floor(v / 31) for v <= 31*255, floor(v / 63) for v <= 63*255,
   // floor(s / 3) for s <= 765: multiply by a rounded-up reciprocal
   localparam logic [31:0] Recip31 = 32'd8457;    // 2^18 / 31, rounded up
   localparam logic [31:0] Recip63 = 32'd16645;   // 2^20 / 63, rounded up
   localparam logic [19:0] Recip3  = 20'd683;     // 2^11 / 3, rounded up

   typedef struct packed {
      logic [7:0] red_a;
      logic [7:0] green_a;
      logic [7:0] blue_a;
      logic [7:0] red_b;
      logic [7:0] green_b;
      logic [7:0] blue_b;
   } chan_type;

   typedef logic [3:0][31:0] palette_type;

   typedef struct packed {
      logic [PosWidth-1:0] first_column;
      logic [PosWidth-1:0] row_base;
      logic [3:0]          mask;
      logic [1:0]          last_row;
      logic                last_block;
   } place_type;

   // c * 255 / 31, truncated
   function automatic logic [7:0] expand5(input logic [4:0] c);
      logic [12:0] v;
      logic [31:0] p;
      v = {c, 8'd0} - 13'(c);
      p = 32'(v) * Recip31;
      return p[25:18];
   endfunction

   // c * 255 / 63, truncated
   function automatic logic [7:0] expand6(input logic [5:0] c);
      logic [13:0] v;
      logic [31:0] p;
      v = {c, 8'd0} - 14'(c);
      p = 32'(v) * Recip63;
      return p[27:20];
   endfunction

   // s / 3, truncated, for sums of three 8-bit channels
   function automatic logic [7:0] third(input logic [9:0] s);
      logic [19:0] p;
      p = 20'(s) * Recip3;
      return p[18:11];
   endfunction

endpackage

### hdl/bc1_place.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC1 block placement
// Holds the block column and line counters, clamps the image size, places
// the current block and works out its column mask, row count and end flags.
// ----------------------------------------------------------------------------
module bc1_place #(
   parameter int MAX_IMAGE_SIZE = 16384
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [bc1_pkg::DimWidth-1:0]     image_width,
   input  logic [bc1_pkg::DimWidth-1:0]     image_height,
   output bc1_pkg::place_type               place
);

   localparam logic [16:0] MaxDim = 17'(MAX_IMAGE_SIZE);

   logic [bc1_pkg::CountWidth-1:0] column_ff, column_in;
   logic [bc1_pkg::CountWidth-1:0] line_ff, line_in;

   logic [bc1_pkg::DimWidth-1:0]   w, h;
   logic [15:0]                    w_sum, h_sum;
   logic [13:0]                    bxs, bys;
   logic [bc1_pkg::CountWidth-1:0] bx, by, line_t;
   logic [bc1_pkg::CountWidth:0]   bx_next, by_next;
   logic [bc1_pkg::PosWidth-1:0]   col0, row0;
   logic [3:0]                     mask, row_ok;

   always_comb begin
      // clamp the sizes to 1 .. MAX_IMAGE_SIZE
      if (image_width == '0) w = bc1_pkg::DimWidth'(1);
      else if ({2'b00, image_width} > MaxDim) w = MaxDim[bc1_pkg::DimWidth-1:0];
      else w = image_width;
      if (image_height == '0) h = bc1_pkg::DimWidth'(1);
      else if ({2'b00, image_height} > MaxDim) h = MaxDim[bc1_pkg::DimWidth-1:0];
      else h = image_height;

      w_sum = {1'b0, w} + 16'd3;
      h_sum = {1'b0, h} + 16'd3;
      bxs   = w_sum[15:2];
      bys   = h_sum[15:2];

      // move a counter that lies beyond the image back inside it
      if ({2'b00, column_ff} >= bxs) begin
         bx     = '0;
         line_t = line_ff + 12'd1;
      end else begin
         bx     = column_ff;
         line_t = line_ff;
      end
      by = ({2'b00, line_t} >= bys) ? '0 : line_t;

      bx_next = {1'b0, bx} + 13'd1;
      by_next = {1'b0, by} + 13'd1;
      col0    = {bx, 2'b00};
      row0    = {by, 2'b00};

      for (int x = 0; x < 4; x++) begin
         mask[x]   = ({1'b0, col0} + 15'(x)) < w;
         row_ok[x] = ({1'b0, row0} + 15'(x)) < h;
      end

      place.first_column = col0;
      place.row_base     = row0;
      place.mask         = mask;
      if (row_ok[3])      place.last_row = 2'd3;
      else if (row_ok[2]) place.last_row = 2'd2;
      else if (row_ok[1]) place.last_row = 2'd1;
      else                place.last_row = 2'd0;
      place.last_block = ({1'b0, bx_next} == bxs) && ({1'b0, by_next} == bys);

      // step to the next block, wrapping at the line and at the image end
      if ({1'b0, bx_next} >= bxs) begin
         column_in = '0;
         line_in   = ({1'b0, by_next} >= bys) ? '0 : by_next[bc1_pkg::CountWidth-1:0];
      end else begin
         column_in = bx_next[bc1_pkg::CountWidth-1:0];
         line_in   = by;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         line_ff   <= '0;
      end else if (advance) begin
         column_ff <= column_in;
         line_ff   <= line_in;
      end
   end

endmodule

### hdl/bc1_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC1 palette builder
// Builds the four RGBA palette entries of a block from its expanded
// endpoint channels: two thirds interpolants, or midpoint and transparent.
// ----------------------------------------------------------------------------
module bc1_palette (
   input  bc1_pkg::chan_type     chan,
   input  logic                  four_color,
   output bc1_pkg::palette_type  palette
);

   logic [7:0] red_2, green_2, blue_2, red_3, green_3, blue_3;
   logic [8:0] red_mid, green_mid, blue_mid;

   always_comb begin
      red_mid   = {1'b0, chan.red_a}   + {1'b0, chan.red_b};
      green_mid = {1'b0, chan.green_a} + {1'b0, chan.green_b};
      blue_mid  = {1'b0, chan.blue_a}  + {1'b0, chan.blue_b};

      if (four_color) begin
         red_2   = bc1_pkg::third({1'b0, chan.red_a, 1'b0}   + {2'b00, chan.red_b});
         green_2 = bc1_pkg::third({1'b0, chan.green_a, 1'b0} + {2'b00, chan.green_b});
         blue_2  = bc1_pkg::third({1'b0, chan.blue_a, 1'b0}  + {2'b00, chan.blue_b});
         red_3   = bc1_pkg::third({2'b00, chan.red_a}   + {1'b0, chan.red_b, 1'b0});
         green_3 = bc1_pkg::third({2'b00, chan.green_a} + {1'b0, chan.green_b, 1'b0});
         blue_3  = bc1_pkg::third({2'b00, chan.blue_a}  + {1'b0, chan.blue_b, 1'b0});
      end else begin
         red_2   = red_mid[8:1];
         green_2 = green_mid[8:1];
         blue_2  = blue_mid[8:1];
         red_3   = '0;
         green_3 = '0;
         blue_3  = '0;
      end

      palette[0] = {bc1_pkg::OpaqueAlpha, chan.blue_a, chan.green_a, chan.red_a};
      palette[1] = {bc1_pkg::OpaqueAlpha, chan.blue_b, chan.green_b, chan.red_b};
      palette[2] = {bc1_pkg::OpaqueAlpha, blue_2, green_2, red_2};
      // transparent black in three-colour mode
      palette[3] = four_color ? {bc1_pkg::OpaqueAlpha, blue_3, green_3, red_3} : '0;
   end

endmodule

### hdl/bc1_block_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC1 block decoder
// Decodes 8-byte BC1 blocks arriving in raster block order into rows of
// four RGBA pixels, masked at the image width and cut at the image height.
//
//   channel  dir  beat
//   req_     in   one BC1 block: endpoints and sixteen 2-bit indices
//   rsp_     out  one pixel row of a block, tlast on its last row,
//                 tuser on the last row of the image
//   csr_     in   one register write: index 0 width, 1 height
//
// A block emits its 1 to 4 rows through the row sequencer, which moves one
// row a cycle into the output register while rsp_ does not stall. A block
// taken is loaded into the row stage and its rows pass from there to the
// output register; the next block is taken in the cycle that moves the last
// row. Reset clears the counters, sets both sizes to 1 and empties the row
// stage and output register. A stall on rsp_ holds the output register and
// the row stage; the next block enters as the last row of the current one
// moves on, and then waits in the row stage while that row is held.
// ----------------------------------------------------------------------------
module bc1_block_decoder #(
   parameter int MAX_IMAGE_SIZE = 16384
) (
   input  logic                            clock,
   input  logic                            reset,
   // block in
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [63:0]                     req_tdata,   // endpoint_a, endpoint_b, index_bits
   // pixel rows out
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [159:0]                    rsp_tdata,   // pixel_row, first_column,
                                                        // valid_mask, pixel_zero,
                                                        // pixel_one, pixel_two,
                                                        // pixel_three
   output logic                            rsp_tlast,   // block_end
   output logic                            rsp_tuser,   // image_end
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_index,
   input  logic [bc1_pkg::DimWidth-1:0]    csr_data
);

   // size registers
   logic [bc1_pkg::DimWidth-1:0] width_ff, height_ff;

   // row stage: the block being emitted
   logic                 hold_valid_ff, hold_valid_in;
   logic [1:0]           row_ff, row_in;
   bc1_pkg::place_type   place_ff;
   bc1_pkg::chan_type    chan_ff;
   logic                 four_color_ff;
   logic [31:0]          index_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [159:0]         rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_user_ff, rsp_user_in;

   bc1_pkg::place_type   place;
   bc1_pkg::chan_type    chan_in;
   bc1_pkg::palette_type palette;

   logic [15:0]          endpoint_a, endpoint_b;
   logic                 out_free, emit, last_emit, accept;
   logic [7:0]           row_index;
   logic [3:0][31:0]     pixel;

   // take every register write at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bc1_pkg::DimWidth'(1);
         height_ff <= bc1_pkg::DimWidth'(1);
      end else if (csr_valid) begin
         case (bc1_pkg::reg_index_type'(csr_index))
            bc1_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_data;
            bc1_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // place the incoming block; advance the counters on each block taken
   bc1_place #(
      .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE)
   ) u_place (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .image_width  (width_ff),
      .image_height (height_ff),
      .place        (place)
   );

   // expand the endpoints on the way in
   assign endpoint_a = req_tdata[15:0];
   assign endpoint_b = req_tdata[31:16];

   always_comb begin
      chan_in.red_a   = bc1_pkg::expand5(endpoint_a[15:11]);
      chan_in.green_a = bc1_pkg::expand6(endpoint_a[10:5]);
      chan_in.blue_a  = bc1_pkg::expand5(endpoint_a[4:0]);
      chan_in.red_b   = bc1_pkg::expand5(endpoint_b[15:11]);
      chan_in.green_b = bc1_pkg::expand6(endpoint_b[10:5]);
      chan_in.blue_b  = bc1_pkg::expand5(endpoint_b[4:0]);
   end

   // handshake: emit a row whenever the output register can take it;
   // take a new block once the current one moves its last row
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign emit       = hold_valid_ff && out_free;
   assign last_emit  = emit && (row_ff == place_ff.last_row);
   assign req_tready = !hold_valid_ff || last_emit;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      row_in        = row_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         row_in        = '0;
      end else if (last_emit) begin
         hold_valid_in = 1'b0;
      end else if (emit) begin
         row_in = row_ff + 2'd1;
      end
   end

   bc1_palette u_palette (
      .chan       (chan_ff),
      .four_color (four_color_ff),
      .palette    (palette)
   );

   // pick the four pixels of the current row; drop those beyond the width
   assign row_index = index_ff[{row_ff, 3'b000} +: 8];

   always_comb begin
      for (int x = 0; x < 4; x++) begin
         pixel[x] = place_ff.mask[x] ? palette[row_index[2*x +: 2]] : '0;
      end
      rsp_data_in = {pixel[3], pixel[2], pixel[1], pixel[0], place_ff.mask,
                     place_ff.first_column, place_ff.row_base[13:2], row_ff};
      rsp_last_in = row_ff == place_ff.last_row;
      rsp_user_in = rsp_last_in && place_ff.last_block;
      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         row_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         row_ff        <= row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload: load a block on accept, a row on emit
   always_ff @(posedge clock) begin
      if (accept) begin
         place_ff      <= place;
         chan_ff       <= chan_in;
         four_color_ff <= endpoint_a > endpoint_b;
         index_ff      <= req_tdata[63:32];
      end
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### test/bc1_block_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC1 block decoder checker
// Watches the register, block and pixel row channels of the decoder. Keeps
// its own copy of the image size and of the block position counters. Decodes
// each accepted block into the pixel rows it must produce, and compares each
// row beat field by field with the oldest pending row.
// ----------------------------------------------------------------------------
module bc1_block_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [63:0]                  req_tdata,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [159:0]                 rsp_tdata,
   input  logic                         rsp_tlast,
   input  logic                         rsp_tuser,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [bc1_pkg::DimWidth-1:0] csr_data,
   output int                           fail_count,
   output int                           rows_pending,
   output int                           rows_checked
);
   import bc1_pkg::*;

   localparam int unsigned MaxSize = 16384;

   typedef struct packed {
      logic [PosWidth-1:0] pixel_row;
      logic [PosWidth-1:0] first_column;
      logic [3:0]          valid_mask;
      logic [3:0][31:0]    pixels;
      logic                block_end;
      logic                image_end;
   } pixel_row_t;

   logic [DimWidth-1:0]   width_reg;
   logic [DimWidth-1:0]   height_reg;
   logic [CountWidth-1:0] tile_column;
   logic [CountWidth-1:0] tile_line;
   pixel_row_t            expected_rows[$];
   int                    mismatches = 0;
   int                    checked = 0;

   assign fail_count   = mismatches;
   assign rows_checked = checked;

   function automatic int unsigned clamp_size(input logic [DimWidth-1:0] v);
      if (v == 0) return 1;
      if (v > MaxSize) return MaxSize;
      return v;
   endfunction

   task automatic report_fault(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
   endtask

   // Place the block, build its palette and queue one row per row inside
   // the image height, then advance the counters.
   task automatic decode_block(input logic [63:0] beat);
      logic [15:0]      end_a;
      logic [15:0]      end_b;
      logic [31:0]      indices;
      int unsigned      wid, hgt, cols, lines, bx, by, col0, rows, sel, x, y;
      int unsigned      ra, ga, ba, rb, gb, bb;
      logic [3:0][31:0] palette;
      logic [3:0]       mask;
      bit               last_tile;
      pixel_row_t       row;
      end_a   = beat[15:0];
      end_b   = beat[31:16];
      indices = beat[63:32];
      wid   = clamp_size(width_reg);
      hgt   = clamp_size(height_reg);
      cols  = (wid + 3) / 4;
      lines = (hgt + 3) / 4;

      // pull counters left beyond the image by a size change back inside
      if (tile_column >= cols) begin
         tile_column = '0;
         tile_line   = tile_line + 1'b1;
      end
      if (tile_line >= lines) tile_line = '0;
      bx = tile_column;
      by = tile_line;

      ra = end_a[15:11] * 32'd255 / 32'd31;
      ga = end_a[10:5]  * 32'd255 / 32'd63;
      ba = end_a[4:0]   * 32'd255 / 32'd31;
      rb = end_b[15:11] * 32'd255 / 32'd31;
      gb = end_b[10:5]  * 32'd255 / 32'd63;
      bb = end_b[4:0]   * 32'd255 / 32'd31;

      palette[0] = {OpaqueAlpha, ba[7:0], ga[7:0], ra[7:0]};
      palette[1] = {OpaqueAlpha, bb[7:0], gb[7:0], rb[7:0]};
      if (end_a > end_b) begin
         palette[2] = {OpaqueAlpha, 8'((2 * ba + bb) / 3), 8'((2 * ga + gb) / 3),
                       8'((2 * ra + rb) / 3)};
         palette[3] = {OpaqueAlpha, 8'((ba + 2 * bb) / 3), 8'((ga + 2 * gb) / 3),
                       8'((ra + 2 * rb) / 3)};
      end else begin
         palette[2] = {OpaqueAlpha, 8'((ba + bb) / 2), 8'((ga + gb) / 2), 8'((ra + rb) / 2)};
         palette[3] = '0;
      end

      col0 = bx * 4;
      for (x = 0; x < 4; x++) mask[x] = (col0 + x < wid);
      rows = 0;
      for (y = 0; y < 4; y++) if (by * 4 + y < hgt) rows++;
      last_tile = (bx + 1 == cols) && (by + 1 == lines);

      for (y = 0; y < rows; y++) begin
         row.pixel_row    = PosWidth'(by * 4 + y);
         row.first_column = PosWidth'(col0);
         row.valid_mask   = mask;
         for (x = 0; x < 4; x++) begin
            sel = (indices >> (2 * (y * 4 + x))) & 32'h3;
            row.pixels[x] = mask[x] ? palette[sel] : 32'h0;
         end
         row.block_end = (y + 1 == rows);
         row.image_end = (y + 1 == rows) && last_tile;
         expected_rows.push_back(row);
      end

      if (bx + 1 >= cols) begin
         tile_column = '0;
         tile_line   = (by + 1 >= lines) ? '0 : CountWidth'(by + 1);
      end else begin
         tile_column = CountWidth'(bx + 1);
      end
   endtask

   always @(posedge clock) begin : watch
      pixel_row_t got;
      pixel_row_t want;
      if (reset) begin
         width_reg   = 1;
         height_reg  = 1;
         tile_column = '0;
         tile_line   = '0;
         expected_rows.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_IMAGE_WIDTH) width_reg = csr_data;
            else height_reg = csr_data;
         end
         // compare before queueing, so a row cannot match a block taken this edge
         if (rsp_tvalid && rsp_tready) begin
            got.pixel_row    = rsp_tdata[13:0];
            got.first_column = rsp_tdata[27:14];
            got.valid_mask   = rsp_tdata[31:28];
            for (int x = 0; x < 4; x++) got.pixels[x] = rsp_tdata[32 + 32 * x +: 32];
            got.block_end = rsp_tlast;
            got.image_end = rsp_tuser;
            if (expected_rows.size() == 0) begin
               report_fault($sformatf("row beat %0d arrived with no row pending", checked));
            end else begin
               want = expected_rows.pop_front();
               if (got.pixel_row !== want.pixel_row)
                  report_fault($sformatf("row beat %0d: pixel_row %0d, want %0d",
                                         checked, got.pixel_row, want.pixel_row));
               if (got.first_column !== want.first_column)
                  report_fault($sformatf("row beat %0d: first_column %0d, want %0d",
                                         checked, got.first_column, want.first_column));
               if (got.valid_mask !== want.valid_mask)
                  report_fault($sformatf("row beat %0d: valid_mask %b, want %b",
                                         checked, got.valid_mask, want.valid_mask));
               for (int x = 0; x < 4; x++)
                  if (got.pixels[x] !== want.pixels[x])
                     report_fault($sformatf("row beat %0d: pixel %0d %h, want %h",
                                            checked, x, got.pixels[x], want.pixels[x]));
               if (got.block_end !== want.block_end)
                  report_fault($sformatf("row beat %0d: block_end %b, want %b",
                                         checked, got.block_end, want.block_end));
               if (got.image_end !== want.image_end)
                  report_fault($sformatf("row beat %0d: image_end %b, want %b",
                                         checked, got.image_end, want.image_end));
            end
            checked++;
         end
         if (req_tvalid && req_tready) decode_block(req_tdata);
      end
      rows_pending <= expected_rows.size();
   end

endmodule

### test/bc1_block_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BC1 block decoder testbench
// Drives BC1 blocks and image size writes into the decoder and takes its
// pixel rows with random stalls. A directed pass covers endpoint extremes,
// both palette modes, masked widths, cut heights, out-of-range sizes and
// size changes mid-image; random phases then decode mostly whole images at
// many sizes. The checker beside the decoder predicts and compares every row.
// ----------------------------------------------------------------------------
module bc1_block_decoder_tb;
   import bc1_pkg::*;

   localparam int NumDirected   = 19;
   localparam int NumRandom     = 430;
   localparam int HoldCycles    = 300;    // long receiver hold-off
   localparam int DrainCycles   = 16;     // settle time after the last row
   localparam int WatchdogLimit = 2000;   // cycles with no beat on any channel

   logic                clock = 1'b0;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [63:0]         req_tdata;    // endpoint_a, endpoint_b, index_bits
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [159:0]        rsp_tdata;    // pixel_row, first_column, valid_mask,
                                      // pixel_zero, pixel_one, pixel_two,
                                      // pixel_three
   logic                rsp_tlast;    // block_end
   logic                rsp_tuser;    // image_end
   logic                csr_valid;
   logic                csr_ready;
   reg_index_type       csr_index;
   logic [DimWidth-1:0] csr_data;

   int fail_count;
   int rows_pending;
   int rows_checked;

   // stimulus bookkeeping
   int blocks_sent  = 0;
   int writes_done  = 0;
   int phase        = 0;
   int cur_width    = 1;
   int cur_height   = 1;
   int quiet_cycles = 0;
   bit tx_idle      = 1'b1;
   bit rx_idle      = 1'b1;
   bit hold_off     = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bc1_block_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bc1_block_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .rows_pending (rows_pending),
      .rows_checked (rows_checked)
   );

   // Offer one block beat after a random gap if tx_idle is set, and hold it
   // until taken; leave tvalid high on return, so a next beat needs no update.
   task automatic send_block(input logic [63:0] beat);
      int gap;
      gap = tx_idle ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      blocks_sent++;
   endtask

   // Drop tvalid and wait until every queued row has come out. The first
   // edge lets the checker count a block taken on the edge just passed.
   task automatic drain_rows();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
   endtask

   // One register beat; drop valid for a cycle so writes never merge.
   task automatic write_reg(input reg_index_type idx, input logic [DimWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      writes_done++;
   endtask

   // Sizes change only once the decoder is empty.
   task automatic set_size(input int wval, input int hval, input bit do_w, input bit do_h);
      drain_rows();
      if (do_w) begin
         write_reg(REG_IMAGE_WIDTH, DimWidth'(wval));
         cur_width = wval;
      end
      if (do_h) begin
         write_reg(REG_IMAGE_HEIGHT, DimWidth'(hval));
         cur_height = hval;
      end
   endtask

   // Mostly small images so that whole images complete; now and then the
   // extremes and values outside the legal range.
   function automatic int pick_size();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return $urandom_range(1, 24);
         6:                return $urandom_range(1, 16384);
         7:                return 0;
         8:                return $urandom_range(16385, 32767);
         default: begin
            case ($urandom_range(0, 2))
               0:       return 1;
               1:       return 16384;
               default: return 32767;
            endcase
         end
      endcase
   endfunction

   // Random endpoints steered into either palette mode, equal endpoints and
   // the extremes; indices mostly random.
   task automatic send_random_block();
      logic [15:0] end_a, end_b, swap;
      logic [31:0] indices;
      end_a = 16'($urandom);
      end_b = 16'($urandom);
      case ($urandom_range(0, 5))
         1: if (end_a < end_b) begin
            swap = end_a; end_a = end_b; end_b = swap;
         end
         2: if (end_a > end_b) begin
            swap = end_a; end_a = end_b; end_b = swap;
         end
         3: end_b = end_a;
         4: begin
            end_a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end_b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         end
         default: ;
      endcase
      indices = $urandom;
      if ($urandom_range(0, 15) == 0) indices = $urandom_range(0, 1) ? '1 : '0;
      send_block({indices, end_b, end_a});
   endtask

   // Receiver: random stalls per row, with a long hold-off on request while
   // the sender keeps offering blocks, so the decoder backs up to its input.
   initial begin : receiver
      int gap;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_off = 1'b0;
         end
         gap = rx_idle ? $urandom_range(0, 8) : 0;
         repeat (gap) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Watchdog: end the run when no channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Watchdog: no beat for %0d cycles, %0d rows still pending",
                     quiet_cycles, rows_pending);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [63:0] beat;
      int          tiles, n, w_eff, h_eff, random_start;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_IMAGE_WIDTH;
      csr_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed pass. Blocks are {indices, endpoint_b, endpoint_a}.
      for (int i = 0; i < NumDirected; i++) begin
         case (i)
            // reset sizes: a one-pixel image, brightest over darkest
            0: beat = {32'hE4E4_E4E4, 16'h0000, 16'hFFFF};
            // 7x6: width masked in the right column, height cut in the lower line
            1: begin
               set_size(7, 6, 1'b1, 1'b1);
               beat = {32'hFFFF_FFFF, 16'hFFFF, 16'h0000};
            end
            2: beat = {32'h1B1B_1B1B, 16'h1234, 16'h1234};  // equal endpoints
            3: beat = {32'h0000_0000, 16'h07E0, 16'hF800};
            4: beat = {32'h55AA_55AA, 16'hFFFF, 16'h001F};  // last block of the image
            5: beat = {32'hAAAA_AAAA, 16'hFFFE, 16'hFFFF};  // first block of the next
            // zero sizes stand for one pixel; counters sit beyond the image
            6: begin
               set_size(0, 0, 1'b1, 1'b1);
               beat = {32'h9C9C_9C9C, 16'h7BEF, 16'h8410};
            end
            7: beat = {32'h3333_CCCC, 16'hF81F, 16'h07E0};
            // oversized values are held at the largest image
            8: begin
               set_size(32767, 16385, 1'b1, 1'b1);
               beat = {32'h0F0F_0F0F, 16'h39E7, 16'hC618};
            end
            9:  beat = {32'hFFFF_0000, 16'hFFFF, 16'hFFFF};
            10: beat = {32'h0000_FFFF, 16'h0000, 16'h0000};
            // shrink mid-line: the column falls outside and moves on a line
            11: begin
               set_size(8, 4, 1'b1, 1'b1);
               beat = {32'h1234_5678, 16'h1357, 16'hABCD};
            end
            12: beat = {32'h8765_4321, 16'h0000, 16'h0001};
            13: beat = {32'hF0F0_F0F0, 16'h0001, 16'h0000};
            14: begin
               set_size(16384, 8, 1'b1, 1'b1);
               beat = {32'hC3C3_C3C3, 16'hAAAA, 16'h5555};
            end
            15: beat = {32'h3C3C_3C3C, 16'h5555, 16'hAAAA};
            16: begin
               set_size(4, 16384, 1'b1, 1'b1);
               beat = {32'h9696_9696, 16'h8000, 16'h7FFF};
            end
            17: beat = {32'h6969_6969, 16'h7FFF, 16'h8000};
            default: beat = {32'hDEAD_BEEF, 16'hBA98, 16'hFEDC};
         endcase
         send_block(beat);
      end

      // Random phases: new sizes, then mostly whole images of random blocks.
      random_start = blocks_sent;
      while (blocks_sent - random_start < NumRandom) begin
         phase++;
         set_size(pick_size(), pick_size(), $urandom_range(0, 3) != 0,
                  $urandom_range(0, 3) != 0);
         tx_idle = $urandom_range(0, 3) != 0;
         rx_idle = $urandom_range(0, 3) != 0;
         w_eff = (cur_width == 0) ? 1 : ((cur_width > 16384) ? 16384 : cur_width);
         h_eff = (cur_height == 0) ? 1 : ((cur_height > 16384) ? 16384 : cur_height);
         tiles = ((w_eff + 3) / 4) * ((h_eff + 3) / 4);
         n = (tiles <= 24) ? tiles * $urandom_range(1, 3) : $urandom_range(8, 40);
         if (phase == 2 || phase == 7) begin
            // keep offering while the receiver holds off
            hold_off = 1'b1;
            tx_idle  = 1'b0;
            n        = 30;
         end
         for (int i = 0; i < n; i++) begin
            send_random_block();
            // now and then pause the sender until every row is out
            if ($urandom_range(0, 39) == 0) drain_rows();
         end
      end

      drain_rows();
      repeat (DrainCycles) @(posedge clock);
      $display("Covered %0d blocks, %0d size writes and %0d random phases",
               blocks_sent, writes_done, phase);
      $display("Checked %0d pixel rows, with two long receiver hold-offs", rows_checked);
      if (fail_count == 0 && rows_pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
